FILE: design/filtered_pid_with_antiwindup_core_defines.svh
// ----------------------------------------------------------------------------
// filtered pid core assertion macros
// Shared assertion wrappers, clocked on the core clock, with or without reset masking.
// ----------------------------------------------------------------------------
`ifndef FILTERED_PID_WITH_ANTIWINDUP_CORE_DEFINES_SVH
`define FILTERED_PID_WITH_ANTIWINDUP_CORE_DEFINES_SVH

// concurrent assertion sampled on clock, masked while reset is high
`define FPID_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// concurrent assertion sampled on clock, also checked during reset
`define FPID_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/fpid_pkg.sv
// ----------------------------------------------------------------------------
// fpid_pkg
// Types and constants of the filtered pid core.
// ----------------------------------------------------------------------------
package fpid_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_ERR,
      ST_MUL_FILT,
      ST_FILT,
      ST_INTEG,
      ST_CLAMP,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM,
      ST_DRIVE
   } state_type;

   // register index on the csr port (byte address / 4)
   localparam logic [2:0] REG_GAIN_P         = 3'd0;
   localparam logic [2:0] REG_GAIN_I         = 3'd1;
   localparam logic [2:0] REG_GAIN_D         = 3'd2;
   localparam logic [2:0] REG_FILTER_WEIGHT  = 3'd3;
   localparam logic [2:0] REG_DRIVE_UPPER    = 3'd4;
   localparam logic [2:0] REG_DRIVE_LOWER    = 3'd5;
   localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;

   // register reset values
   localparam logic [8:0]         WEIGHT_RESET = 9'd256;
   localparam logic signed [15:0] UPPER_RESET  = 16'sh7FFF;
   localparam logic signed [15:0] LOWER_RESET  = 16'sh8000;
   localparam logic [30:0]        LIMIT_RESET  = 31'h7FFF_FFFF;

   // full-scale filter weight (1.0 in q1.8)
   localparam logic [8:0] WEIGHT_ONE = 9'd256;

endpackage

FILE: design/filtered_pid_with_antiwindup_core.sv
// ----------------------------------------------------------------------------
// filtered_pid_with_antiwindup_core
// PID controller with a low-pass filtered error, conditional integration
// anti-windup and a clamped drive output.
// ----------------------------------------------------------------------------
// One control step runs from the accepting edge until the core is ready
// again: the five products (two for the error filter, three for the gains)
// pass one after another through a single shared 17x32 signed multiplier,
// with the filter, integrator and clamp adds in between. A clear action
// (req_tuser = 1) zeroes the filter, the integrator and the last drive and
// returns drive 0. The result sits in an output register and the core waits
// there only if rsp_tready holds it back. Registers are to be written over
// the csr port only while no step is in flight; the core does not enforce it.
`include "filtered_pid_with_antiwindup_core_defines.svh"

module filtered_pid_with_antiwindup_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] setpoint, [31:16] measured
   input  logic [0:0]  req_tuser,   // [0] action (1 = clear all state)
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] drive
   output logic [0:0]  rsp_tuser,   // [0] clamped
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [8:0]  weight_ff;
   logic signed [15:0] upper_ff, lower_ff;
   logic        [30:0] limit_ff;

   // sequencer
   fpid_pkg::state_type state_ff, state_in;

   // controller state
   logic signed [25:0] filt_ff;
   logic signed [31:0] integ_ff;
   logic signed [15:0] last_drive_ff;

   // step working registers
   logic signed [16:0] err_ff;
   logic signed [25:0] fnew_ff;
   logic signed [26:0] diff_ff;
   logic signed [32:0] sum_ff;
   logic               block_ff;
   logic               clear_ff;
   logic signed [48:0] prod_ff;
   logic signed [48:0] acc_ff;

   // output register
   logic               rsp_tvalid_ff;
   logic signed [15:0] drive_ff;
   logic               clamped_ff;

   // shared multiplier
   logic signed [16:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [48:0] mul_p;

   // misc combinational
   logic               req_xfer;
   logic               csr_write;
   logic               slot_free;
   logic               load_out;
   logic        [8:0]  weight_c;
   logic        [8:0]  weight_comp;
   logic signed [25:0] fnew_c;
   logic signed [32:0] limit_pos;
   logic signed [32:0] limit_neg;
   logic signed [31:0] integ_c;
   logic signed [32:0] drive_wide;
   logic signed [32:0] upper_wide;
   logic signed [32:0] lower_wide;
   logic signed [15:0] drive_c;
   logic               clamped_c;

   // handshakes
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         weight_ff <= fpid_pkg::WEIGHT_RESET;
         upper_ff  <= fpid_pkg::UPPER_RESET;
         lower_ff  <= fpid_pkg::LOWER_RESET;
         limit_ff  <= fpid_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            fpid_pkg::REG_GAIN_P:         gain_p_ff <= csr_pwdata[15:0];
            fpid_pkg::REG_GAIN_I:         gain_i_ff <= csr_pwdata[15:0];
            fpid_pkg::REG_GAIN_D:         gain_d_ff <= csr_pwdata[15:0];
            fpid_pkg::REG_FILTER_WEIGHT:  weight_ff <= csr_pwdata[8:0];
            fpid_pkg::REG_DRIVE_UPPER:    upper_ff  <= csr_pwdata[15:0];
            fpid_pkg::REG_DRIVE_LOWER:    lower_ff  <= csr_pwdata[15:0];
            fpid_pkg::REG_INTEGRAL_LIMIT: limit_ff  <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[4:2])
         fpid_pkg::REG_GAIN_P:         csr_prdata = 32'(gain_p_ff);
         fpid_pkg::REG_GAIN_I:         csr_prdata = 32'(gain_i_ff);
         fpid_pkg::REG_GAIN_D:         csr_prdata = 32'(gain_d_ff);
         fpid_pkg::REG_FILTER_WEIGHT:  csr_prdata = {23'd0, weight_ff};
         fpid_pkg::REG_DRIVE_UPPER:    csr_prdata = 32'(upper_ff);
         fpid_pkg::REG_DRIVE_LOWER:    csr_prdata = 32'(lower_ff);
         fpid_pkg::REG_INTEGRAL_LIMIT: csr_prdata = {1'b0, limit_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpid_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = req_tuser[0] ? fpid_pkg::ST_DRIVE : fpid_pkg::ST_MUL_ERR;
            end
         end
         fpid_pkg::ST_MUL_ERR:  state_in = fpid_pkg::ST_MUL_FILT;
         fpid_pkg::ST_MUL_FILT: state_in = fpid_pkg::ST_FILT;
         fpid_pkg::ST_FILT:     state_in = fpid_pkg::ST_INTEG;
         fpid_pkg::ST_INTEG:    state_in = fpid_pkg::ST_CLAMP;
         fpid_pkg::ST_CLAMP:    state_in = fpid_pkg::ST_MUL_I;
         fpid_pkg::ST_MUL_I:    state_in = fpid_pkg::ST_MUL_D;
         fpid_pkg::ST_MUL_D:    state_in = fpid_pkg::ST_SUM;
         fpid_pkg::ST_SUM:      state_in = fpid_pkg::ST_DRIVE;
         fpid_pkg::ST_DRIVE: begin
            if (slot_free) begin
               state_in = fpid_pkg::ST_IDLE;
            end
         end
         default:               state_in = fpid_pkg::ST_IDLE;
      endcase
   end

   // effective filter weight, anything above 1.0 acts as 1.0
   assign weight_c    = weight_ff[8] ? fpid_pkg::WEIGHT_ONE : weight_ff;
   assign weight_comp = fpid_pkg::WEIGHT_ONE - weight_c;

   // sequencer outputs: ready, output load and multiplier operand select
   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         fpid_pkg::ST_IDLE: req_tready = 1'b1;
         fpid_pkg::ST_MUL_ERR: begin
            mul_a = signed'({8'd0, weight_c});
            mul_b = 32'(err_ff);
         end
         fpid_pkg::ST_MUL_FILT: begin
            mul_a = signed'({8'd0, weight_comp});
            mul_b = 32'(filt_ff);
         end
         fpid_pkg::ST_CLAMP: begin
            mul_a = 17'(gain_p_ff);
            mul_b = 32'(fnew_ff);
         end
         fpid_pkg::ST_MUL_I: begin
            mul_a = 17'(gain_i_ff);
            mul_b = integ_ff;
         end
         fpid_pkg::ST_MUL_D: begin
            mul_a = 17'(gain_d_ff);
            mul_b = 32'(diff_ff);
         end
         fpid_pkg::ST_DRIVE: load_out = slot_free;
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // filter update: w*e + floor((256-w)*f / 256)
   assign fnew_c = 26'(acc_ff + (prod_ff >>> 8));

   // integrator clamp to +-limit
   assign limit_pos = signed'({2'b00, limit_ff});
   assign limit_neg = -limit_pos;
   always_comb begin
      if (sum_ff > limit_pos) begin
         integ_c = 32'(limit_pos);
      end else if (sum_ff < limit_neg) begin
         integ_c = 32'(limit_neg);
      end else begin
         integ_c = 32'(sum_ff);
      end
   end

   // drive: floor(acc / 65536), upper bound tested first
   assign drive_wide = 33'(acc_ff >>> 16);
   assign upper_wide = 33'(upper_ff);
   assign lower_wide = 33'(lower_ff);
   always_comb begin
      drive_c   = 16'(drive_wide);
      clamped_c = 1'b0;
      if (clear_ff) begin
         drive_c = '0;
      end else if (drive_wide > upper_wide) begin
         drive_c   = upper_ff;
         clamped_c = 1'b1;
      end else if (drive_wide < lower_wide) begin
         drive_c   = lower_ff;
         clamped_c = 1'b1;
      end
   end

   // control state and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fpid_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         filt_ff       <= '0;
         integ_ff      <= '0;
         last_drive_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (req_xfer && req_tuser[0]) begin
            filt_ff       <= '0;
            integ_ff      <= '0;
            last_drive_ff <= '0;
         end
         if (state_ff == fpid_pkg::ST_INTEG) begin
            filt_ff <= fnew_ff;
         end
         if (state_ff == fpid_pkg::ST_CLAMP && !block_ff) begin
            integ_ff <= integ_c;
         end
         if (load_out) begin
            last_drive_ff <= drive_c;
         end
      end
   end

   // datapath working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         fpid_pkg::ST_IDLE: begin
            clear_ff <= req_tuser[0];
            err_ff   <= 17'(signed'(req_tdata[15:0])) - 17'(signed'(req_tdata[31:16]));
         end
         fpid_pkg::ST_MUL_ERR: prod_ff <= mul_p;
         fpid_pkg::ST_MUL_FILT: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_p;
         end
         fpid_pkg::ST_FILT: fnew_ff <= fnew_c;
         fpid_pkg::ST_INTEG: begin
            diff_ff  <= 27'(fnew_ff) - 27'(filt_ff);
            sum_ff   <= 33'(integ_ff) + 33'(fnew_ff);
            block_ff <= ((last_drive_ff >= upper_ff) && !fnew_ff[25] && (fnew_ff != '0))
                     || ((last_drive_ff <= lower_ff) && fnew_ff[25]);
         end
         fpid_pkg::ST_CLAMP: prod_ff <= mul_p;
         fpid_pkg::ST_MUL_I: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_p;
         end
         fpid_pkg::ST_MUL_D: begin
            acc_ff  <= acc_ff + prod_ff;
            prod_ff <= mul_p;
         end
         fpid_pkg::ST_SUM: acc_ff <= acc_ff + prod_ff;
         default: ;
      endcase
      if (load_out) begin
         drive_ff   <= drive_c;
         clamped_ff <= clamped_c;
      end
   end

   // response ports
   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = drive_ff;
   assign rsp_tuser[0] = clamped_ff;

   // assertions
   `FPID_ASSERT(a_clear_zeroes_state, req_xfer && req_tuser[0] |=> filt_ff == '0 && integ_ff == '0 && last_drive_ff == '0, "clear transfer did not zero controller state")
   `FPID_ASSERT(a_clamped_at_bound, rsp_tvalid_ff && clamped_ff |-> drive_ff == upper_ff || drive_ff == lower_ff, "clamped result not at a drive bound")
   `FPID_ASSERT(a_result_from_drive, $rose(rsp_tvalid_ff) |-> $past(state_ff) == fpid_pkg::ST_DRIVE, "response raised outside the drive step")
   `FPID_ASSERT(a_drive_load_lands, state_ff == fpid_pkg::ST_DRIVE && slot_free |=> rsp_tvalid_ff && state_ff == fpid_pkg::ST_IDLE, "drive step did not post a response")

endmodule
